// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the checker files of this core.
// No dependencies; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/lspe_pkg.sv -----
// Shared types and constants of the LSB stego payload extractor.
// No dependencies; used by every module of the core.
package lspe_pkg;

  // Frame phases of the hidden stream.
  typedef enum logic [2:0] {
    PH_SKIP,
    PH_MAGIC,
    PH_EXTLEN,
    PH_EXT,
    PH_PAYLEN,
    PH_PAY,
    PH_STOP
  } lspe_phase_t;

  // Result kinds.
  localparam logic [1:0] KIND_EXT    = 2'd0;
  localparam logic [1:0] KIND_PAY    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MAGIC_BAD = 2'd1;
  localparam logic [1:0] ST_EXT_LONG  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_HEADER_LENGTH = 2'd0;
  localparam logic [1:0] REG_MAGIC_FIRST   = 2'd1;
  localparam logic [1:0] REG_MAGIC_SECOND  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [15:0] HEADER_LENGTH_RST = 16'd54;
  localparam logic [7:0]  MAGIC_FIRST_RST   = 8'd35;
  localparam logic [7:0]  MAGIC_SECOND_RST  = 8'd42;

  // Extension lengths at or above this bound are rejected.
  localparam int unsigned EXT_CAP = 8;

  // Configuration seen by the frame logic.
  typedef struct packed {
    logic [15:0] header_length;
    logic [7:0]  magic_first;
    logic [7:0]  magic_second;
  } lspe_cfg_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [1:0] status;
    logic       last;
  } lspe_res_t;

endpackage

// ----- rtl/core/lsb_stego_payload_extractor_core.sv -----
// Top level of the LSB stego payload extractor core.
// Depends on lspe_pkg, lspe_frame_fsm and lspe_out_buf.
//
//  Channel | Ports                           | Carries
//  in      | in_tvalid/in_tready/in_tdata    | image_byte
//  out     | out_tvalid/out_tready/tdata/... | out_byte; tuser kind, status; tlast last
//  cfg     | cfg_valid/cfg_ready/index/data  | register writes
//
// One image byte is accepted per cycle; its result, if any, is registered into
// a two-entry output buffer behind any older results. Input is held off only
// when that buffer is full. Reset is synchronous and active low; no clearing
// pass is needed. Configuration writes are always accepted.
module lsb_stego_payload_extractor_core #(
  parameter int unsigned EXT_CAP = lspe_pkg::EXT_CAP
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] image_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [3:0]  out_tuser,  // [1:0] kind, [3:2] status
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  lspe_pkg::lspe_cfg_t cfg_r, cfg_nxt;
  lspe_pkg::lspe_res_t res, out_res;
  logic res_valid;
  logic buf_not_full;
  logic in_fire;

  assign cfg_ready = 1'b1;
  assign in_tready = buf_not_full;
  assign in_fire   = in_tvalid && in_tready;

  // Configuration register writes; unknown indexes are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lspe_pkg::REG_HEADER_LENGTH: cfg_nxt.header_length = cfg_data;
        lspe_pkg::REG_MAGIC_FIRST:   cfg_nxt.magic_first   = cfg_data[7:0];
        lspe_pkg::REG_MAGIC_SECOND:  cfg_nxt.magic_second  = cfg_data[7:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{header_length: lspe_pkg::HEADER_LENGTH_RST,
                 magic_first:   lspe_pkg::MAGIC_FIRST_RST,
                 magic_second:  lspe_pkg::MAGIC_SECOND_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lspe_frame_fsm #(
    .EXT_CAP (EXT_CAP)
  ) u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .image_byte (in_tdata),
    .cfg        (cfg_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  lspe_out_buf u_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .not_full   (buf_not_full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_data   (out_res)
  );

  // Result fields onto the stream ports.
  assign out_tdata = out_res.out_byte;
  assign out_tuser = {out_res.status, out_res.kind};
  assign out_tlast = out_res.last;

endmodule

// ----- rtl/core/lspe_frame_fsm.sv -----
// Frame decoder: header skip, bit gathering and the hidden frame state machine.
// Depends on lspe_pkg; produces at most one result per accepted byte.
module lspe_frame_fsm #(
  parameter int unsigned EXT_CAP = lspe_pkg::EXT_CAP
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [7:0]         image_byte,
  input  lspe_pkg::lspe_cfg_t cfg,
  output logic               res_valid,
  output lspe_pkg::lspe_res_t res
);

  lspe_pkg::lspe_phase_t phase_r, phase_nxt;
  logic [15:0] skip_r, skip_nxt;
  logic [2:0]  bit_cnt_r, bit_cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [1:0]  fidx_r, fidx_nxt;
  logic [23:0] gather_r, gather_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic        magic_ok_r, magic_ok_nxt;

  // Next state: one byte is fully handled in the cycle it is accepted.
  always_comb begin
    lspe_pkg::lspe_phase_t ph;
    logic        do_bits;
    logic [7:0]  sh;
    logic [31:0] sz_raw;
    logic [30:0] sz;
    logic        ok;

    phase_nxt    = phase_r;
    skip_nxt     = skip_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    fidx_nxt     = fidx_r;
    gather_nxt   = gather_r;
    rem_nxt      = rem_r;
    magic_ok_nxt = magic_ok_r;
    res_valid    = 1'b0;
    res          = '0;
    ph           = phase_r;
    do_bits      = 1'b0;
    sh           = {shift_r[6:0], image_byte[0]};
    sz_raw       = {sh, gather_r};
    sz           = sz_raw[31] ? 31'd0 : sz_raw[30:0];
    ok           = magic_ok_r && (sh == cfg.magic_second);

    if (in_fire && (phase_r != lspe_pkg::PH_STOP)) begin
      do_bits = 1'b1;
      // Header skip; the byte that ends the skip is already hidden data.
      if (phase_r == lspe_pkg::PH_SKIP) begin
        if (skip_r < cfg.header_length) begin
          skip_nxt = skip_r + 16'd1;
          do_bits  = 1'b0;
        end else begin
          ph        = lspe_pkg::PH_MAGIC;
          phase_nxt = lspe_pkg::PH_MAGIC;
          fidx_nxt  = 2'd0;
        end
      end
    end

    if (do_bits) begin
      if (bit_cnt_r != 3'd7) begin
        bit_cnt_nxt = bit_cnt_r + 3'd1;
        shift_nxt   = sh;
      end else begin
        bit_cnt_nxt = 3'd0;
        shift_nxt   = 8'd0;
        case (ph)
          lspe_pkg::PH_MAGIC: begin
            if (fidx_nxt == 2'd0) begin
              magic_ok_nxt = (sh == cfg.magic_first);
              fidx_nxt     = 2'd1;
            end else if (!ok) begin
              magic_ok_nxt = 1'b0;
              phase_nxt    = lspe_pkg::PH_STOP;
              res_valid    = 1'b1;
              res = '{out_byte: 8'd0, kind: lspe_pkg::KIND_STATUS,
                      status: lspe_pkg::ST_MAGIC_BAD, last: 1'b1};
            end else begin
              phase_nxt  = lspe_pkg::PH_EXTLEN;
              fidx_nxt   = 2'd0;
              gather_nxt = 24'd0;
            end
          end
          lspe_pkg::PH_EXTLEN, lspe_pkg::PH_PAYLEN: begin
            // Little-endian length, completed by the fourth byte.
            if (fidx_r != 2'd3) begin
              case (fidx_r)
                2'd0:    gather_nxt[7:0]   = sh;
                2'd1:    gather_nxt[15:8]  = sh;
                default: gather_nxt[23:16] = sh;
              endcase
              fidx_nxt = fidx_r + 2'd1;
            end else begin
              fidx_nxt   = 2'd0;
              gather_nxt = 24'd0;
              if (ph == lspe_pkg::PH_EXTLEN) begin
                if (sz >= 31'(EXT_CAP)) begin
                  phase_nxt = lspe_pkg::PH_STOP;
                  res_valid = 1'b1;
                  res = '{out_byte: 8'd0, kind: lspe_pkg::KIND_STATUS,
                          status: lspe_pkg::ST_EXT_LONG, last: 1'b1};
                end else begin
                  rem_nxt   = sz;
                  phase_nxt = (sz == 31'd0) ? lspe_pkg::PH_PAYLEN : lspe_pkg::PH_EXT;
                end
              end else if (sz == 31'd0) begin
                // Empty payload ends the frame with a status result.
                phase_nxt = lspe_pkg::PH_STOP;
                res_valid = 1'b1;
                res = '{out_byte: 8'd0, kind: lspe_pkg::KIND_STATUS,
                        status: lspe_pkg::ST_OK, last: 1'b1};
              end else begin
                rem_nxt   = sz;
                phase_nxt = lspe_pkg::PH_PAY;
              end
            end
          end
          lspe_pkg::PH_EXT: begin
            rem_nxt   = rem_r - 31'd1;
            res_valid = 1'b1;
            res = '{out_byte: sh, kind: lspe_pkg::KIND_EXT,
                    status: lspe_pkg::ST_OK, last: 1'b0};
            if (rem_r == 31'd1) begin
              phase_nxt  = lspe_pkg::PH_PAYLEN;
              fidx_nxt   = 2'd0;
              gather_nxt = 24'd0;
            end
          end
          lspe_pkg::PH_PAY: begin
            rem_nxt   = rem_r - 31'd1;
            res_valid = 1'b1;
            res = '{out_byte: sh, kind: lspe_pkg::KIND_PAY,
                    status: lspe_pkg::ST_OK, last: (rem_r == 31'd1)};
            if (rem_r == 31'd1) begin
              phase_nxt = lspe_pkg::PH_STOP;
            end
          end
          default: begin
            phase_nxt = lspe_pkg::PH_STOP;
          end
        endcase
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= lspe_pkg::PH_SKIP;
      skip_r     <= 16'd0;
      bit_cnt_r  <= 3'd0;
      shift_r    <= 8'd0;
      fidx_r     <= 2'd0;
      gather_r   <= 24'd0;
      rem_r      <= 31'd0;
      magic_ok_r <= 1'b1;
    end else begin
      phase_r    <= phase_nxt;
      skip_r     <= skip_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      fidx_r     <= fidx_nxt;
      gather_r   <= gather_nxt;
      rem_r      <= rem_nxt;
      magic_ok_r <= magic_ok_nxt;
    end
  end

endmodule

// ----- rtl/core/lspe_out_buf.sv -----
// Two-entry result buffer between the frame decoder and the output channel.
// Depends on lspe_pkg for the result type.
module lspe_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lspe_pkg::lspe_res_t push_data,
  output logic                not_full,
  output logic                out_tvalid,
  input  logic                out_tready,
  output lspe_pkg::lspe_res_t out_data
);

  lspe_pkg::lspe_res_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       pop;

  assign pop        = out_tvalid && out_tready;
  assign not_full   = (count_r != 2'd2);
  assign out_tvalid = (count_r != 2'd0);
  assign out_data   = mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/lspe_checker.sv -----
// Port-level checker for the LSB stego payload extractor core, with its bind.
// Depends on lspe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lspe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [3:0] out_tuser,
  input logic       out_tlast
);

  logic        out_stall;
  logic        out_fire;
  logic        is_status;
  logic        is_error;
  logic [12:0] out_word;

  assign out_stall = out_tvalid && !out_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign is_status = (out_tuser[1:0] == lspe_pkg::KIND_STATUS);
  assign is_error  = (out_tuser[3:2] != lspe_pkg::ST_OK);
  assign out_word  = {out_tlast, out_tuser, out_tdata};

  // A stalled transaction keeps its contents.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_word))

  // Status-only transactions carry a zero byte and close the frame.
  `ASSERT_SAME(a_status_shape, clk, rst_n, out_tvalid && is_status, (out_tdata == 8'd0) && out_tlast)

  // An error code appears only on a status-only transaction.
  `ASSERT_SAME(a_err_kind, clk, rst_n, out_tvalid && is_error, is_status)

  // Nothing follows the transaction that ends the frame.
  `ASSERT_NEXT(a_after_last, clk, rst_n, out_fire && out_tlast, !out_tvalid)

endmodule

bind lsb_stego_payload_extractor_core lspe_checker u_lspe_checker (.*);

// ----- bench/lsb_stego_payload_extractor_core_test.sv -----
// Self-checking bench for lsb_stego_payload_extractor_core: drives one hidden frame
// through the carrier stream and checks every result against a bit-level predictor.
// Depends on lspe_pkg and the RTL of the core; reads no files.
module lsb_stego_payload_extractor_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Index outside the register map; writes to it must be dropped.
  localparam logic [1:0] REG_UNMAPPED = 2'd3;
  // Cycles to let the core settle after the last result before touching config.
  localparam int DRAIN_CYCLES = 4;
  // Receiver hold-off used to fill the output buffer and stall the input.
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] image_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;          // [7:0] out_byte
  logic [3:0]  out_tuser;          // [1:0] kind, [3:2] status
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'h0000;

  // Decoder state as the predictor tracks it.
  lspe_pkg::lspe_cfg_t   dec_cfg = '{lspe_pkg::HEADER_LENGTH_RST,
                                     lspe_pkg::MAGIC_FIRST_RST,
                                     lspe_pkg::MAGIC_SECOND_RST};
  lspe_pkg::lspe_phase_t dec_phase = lspe_pkg::PH_SKIP;
  logic [15:0] dec_skip = '0;
  logic [2:0]  dec_bits = '0;
  logic [7:0]  dec_shift = '0;
  logic [31:0] dec_field = '0;
  logic [31:0] dec_size = '0;
  logic [31:0] dec_left = '0;
  logic        dec_magic_ok = 1'b1;

  // Hidden-byte and status results still owed by the core, oldest first.
  lspe_pkg::lspe_res_t due_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int error_count = 0;
  int images_sent = 0;
  int results_seen = 0;
  int stall_cycles = 0;
  int cycle_count = 0;
  int payload_len = 0;

  lsb_stego_payload_extractor_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Advance the decoder by one carrier byte; returns 1 when a result is due.
  function automatic bit decode_carrier_byte(input logic [7:0] img,
                                             output lspe_pkg::lspe_res_t res);
    logic [7:0]  hid;
    logic [31:0] sz;
    res = '0;
    if (dec_phase == lspe_pkg::PH_STOP) return 1'b0;
    if (dec_phase == lspe_pkg::PH_SKIP) begin
      if (dec_skip < dec_cfg.header_length) begin
        dec_skip = dec_skip + 16'd1;
        return 1'b0;
      end
      dec_phase = lspe_pkg::PH_MAGIC;
      dec_field = '0;
    end
    // Gather the carrier LSBs, most significant bit first.
    dec_shift = {dec_shift[6:0], img[0]};
    if (dec_bits < 3'd7) begin
      dec_bits = dec_bits + 3'd1;
      return 1'b0;
    end
    dec_bits = '0;
    hid = dec_shift;
    dec_shift = '0;
    case (dec_phase)
      lspe_pkg::PH_MAGIC: begin
        if (dec_field == 0) begin
          dec_magic_ok = (hid == dec_cfg.magic_first);
          dec_field = 1;
          return 1'b0;
        end
        if (hid != dec_cfg.magic_second) dec_magic_ok = 1'b0;
        if (!dec_magic_ok) begin
          dec_phase = lspe_pkg::PH_STOP;
          res = '{out_byte: 8'h00, kind: lspe_pkg::KIND_STATUS,
                  status: lspe_pkg::ST_MAGIC_BAD, last: 1'b1};
          return 1'b1;
        end
        dec_phase = lspe_pkg::PH_EXTLEN;
        dec_field = '0;
        dec_size = '0;
        return 1'b0;
      end
      lspe_pkg::PH_EXTLEN, lspe_pkg::PH_PAYLEN: begin
        // Both length fields are 4 bytes, little endian; a set top bit means zero.
        dec_size = dec_size | ({24'h0, hid} << (8 * dec_field[1:0]));
        if (dec_field < 3) begin
          dec_field = dec_field + 1;
          return 1'b0;
        end
        dec_field = '0;
        sz = dec_size;
        dec_size = '0;
        if (sz[31]) sz = '0;
        if (dec_phase == lspe_pkg::PH_EXTLEN) begin
          if (sz >= lspe_pkg::EXT_CAP) begin
            dec_phase = lspe_pkg::PH_STOP;
            res = '{out_byte: 8'h00, kind: lspe_pkg::KIND_STATUS,
                    status: lspe_pkg::ST_EXT_LONG, last: 1'b1};
            return 1'b1;
          end
          dec_left = sz;
          if (sz == 0) dec_phase = lspe_pkg::PH_PAYLEN;
          else dec_phase = lspe_pkg::PH_EXT;
          return 1'b0;
        end
        if (sz == 0) begin
          dec_phase = lspe_pkg::PH_STOP;
          res = '{out_byte: 8'h00, kind: lspe_pkg::KIND_STATUS,
                  status: lspe_pkg::ST_OK, last: 1'b1};
          return 1'b1;
        end
        dec_left = sz;
        dec_phase = lspe_pkg::PH_PAY;
        return 1'b0;
      end
      lspe_pkg::PH_EXT: begin
        dec_left = dec_left - 1;
        if (dec_left == 0) begin
          dec_phase = lspe_pkg::PH_PAYLEN;
          dec_field = '0;
          dec_size = '0;
        end
        res = '{out_byte: hid, kind: lspe_pkg::KIND_EXT,
                status: lspe_pkg::ST_OK, last: 1'b0};
        return 1'b1;
      end
      default: begin
        dec_left = dec_left - 1;
        res = '{out_byte: hid, kind: lspe_pkg::KIND_PAY,
                status: lspe_pkg::ST_OK, last: (dec_left == 0)};
        if (dec_left == 0) dec_phase = lspe_pkg::PH_STOP;
        return 1'b1;
      end
    endcase
  endfunction

  // Offer one carrier byte, wait for its transaction and record what it owes.
  // Entered and left at a falling edge.
  task automatic send_image_byte(input logic [7:0] img);
    lspe_pkg::lspe_res_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= img;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    images_sent++;
    if (decode_carrier_byte(img, res)) due_results.push_back(res);
    @(negedge clk);
  endtask

  // Spread one hidden byte over the LSBs of eight random carrier bytes.
  task automatic send_hidden_byte(input logic [7:0] hid);
    logic [7:0] img;
    for (int i = 7; i >= 0; i--) begin
      img = 8'($urandom);
      img[0] = hid[i];
      send_image_byte(img);
    end
  endtask

  task automatic send_hidden_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) send_hidden_byte(w[8*k +: 8]);
  endtask

  // Stop offering input and wait until every owed result has come out.
  task automatic drain_results;
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One register write transaction; the predictor copy follows it.
  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      lspe_pkg::REG_HEADER_LENGTH: dec_cfg.header_length = data;
      lspe_pkg::REG_MAGIC_FIRST:   dec_cfg.magic_first = data[7:0];
      lspe_pkg::REG_MAGIC_SECOND:  dec_cfg.magic_second = data[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Header skip: a huge length, then shorter ones written while skipping.
  task automatic test_header_skip;
    send_idle_pct = 7;
    recv_idle_pct = 87;
    cfg_write(lspe_pkg::REG_HEADER_LENGTH, 16'hFFFF);
    cfg_write(lspe_pkg::REG_MAGIC_FIRST, 16'h0000);
    cfg_write(lspe_pkg::REG_MAGIC_SECOND, 16'h00FF);
    cfg_write(REG_UNMAPPED, 16'($urandom));
    send_image_byte(8'h00);
    send_image_byte(8'hFF);
    for (int i = 0; i < 4; i++) send_image_byte(8'($urandom));
    drain_results();
    cfg_write(lspe_pkg::REG_HEADER_LENGTH, 16'd9);
    for (int i = 0; i < 3; i++) send_image_byte(8'($urandom));
    drain_results();
    // Skip count already reached; the next byte starts the hidden stream.
    cfg_write(lspe_pkg::REG_HEADER_LENGTH, 16'd0);
  endtask

  // Magic bytes at the value extremes, carried by extreme image bytes.
  task automatic test_magic_match;
    for (int i = 0; i < 8; i++) send_image_byte((i % 2) ? 8'hFE : 8'h00);
    for (int i = 0; i < 8; i++) send_image_byte((i % 2) ? 8'h01 : 8'hFF);
    drain_results();
    // Writes after the magic check must not disturb the frame.
    cfg_write(lspe_pkg::REG_MAGIC_FIRST, 16'(lspe_pkg::MAGIC_FIRST_RST));
    cfg_write(lspe_pkg::REG_MAGIC_SECOND, 16'(lspe_pkg::MAGIC_SECOND_RST));
    cfg_write(lspe_pkg::REG_HEADER_LENGTH, 16'($urandom));
  endtask

  // Longest extension the core accepts, then a pause until it has all come out.
  task automatic test_extension_bytes;
    logic [7:0] ext_bytes[4];
    ext_bytes = '{8'h00, 8'hFF, 8'h80, 8'h01};
    send_hidden_word(32'(lspe_pkg::EXT_CAP - 1));
    for (int i = 0; i < lspe_pkg::EXT_CAP - 1; i++)
      send_hidden_byte((i < 4) ? ext_bytes[i] : 8'($urandom));
    drain_results();
  endtask

  // Long payload: slow sender first, then full rate with a receiver hold-off.
  task automatic test_payload_under_backpressure;
    logic [7:0] hid;
    send_idle_pct = 87;
    recv_idle_pct = 7;
    payload_len = $urandom_range(118, 104);
    send_hidden_word(32'(payload_len));
    for (int i = 0; i < payload_len; i++) begin
      if (i == payload_len / 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
      end
      case (i)
        0: hid = 8'hFF;
        1: hid = 8'h00;
        2: hid = 8'h5A;
        3: hid = 8'hA5;
        default: hid = 8'($urandom);
      endcase
      send_hidden_byte(hid);
    end
  endtask

  // After the final payload byte every further image byte is dropped.
  task automatic test_stopped_after_frame;
    for (int i = 0; i < 16; i++) send_image_byte(8'($urandom));
    drain_results();
  endtask

  // Receiver: random ready, or a long hold-off when one is requested.
  initial begin : receiver
    int served;
    served = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != served) begin
        served = hold_requests;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic bit field_ok(input string label, input logic [7:0] want,
                                  input logic [7:0] got);
    if (want === got) return 1'b1;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
    return 1'b0;
  endfunction

  // Compare each result transaction with the oldest owed result.
  always @(posedge clk) begin : result_compare
    lspe_pkg::lspe_res_t want;
    bit bad;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        $display({"%0t: unexpected result, expected none, ",
                  "actual byte %0h kind %0d status %0d last %0d"},
                 $time, out_tdata, out_tuser[1:0], out_tuser[3:2], out_tlast);
        error_count++;
      end else begin
        want = due_results.pop_front();
        bad = !field_ok("out_byte", want.out_byte, out_tdata)
            | !field_ok("kind", 8'(want.kind), 8'(out_tuser[1:0]))
            | !field_ok("status", 8'(want.status), 8'(out_tuser[3:2]))
            | !field_ok("last", 8'(want.last), 8'(out_tlast));
        if (bad) error_count++;
      end
    end
  end

  // Watchdog and input stall count.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (in_tvalid && !in_tready) stall_cycles <= stall_cycles + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
      $display("lsb_stego_payload_extractor_core: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_header_skip();
    test_magic_match();
    test_extension_bytes();
    test_payload_under_backpressure();
    test_stopped_after_frame();
    repeat (16) @(posedge clk);
    $display("Run covered %0d image bytes, %0d results, %0d stalled input cycles:",
             images_sent, results_seen, stall_cycles);
    $display("  header skip rewrites, extreme magic, %0d-byte extension, %0d-byte payload.",
             lspe_pkg::EXT_CAP - 1, payload_len);
    if (error_count == 0)
      $display("lsb_stego_payload_extractor_core: match");
    else
      $display("lsb_stego_payload_extractor_core: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/lspe_pkg.sv
rtl/core/lspe_frame_fsm.sv
rtl/core/lspe_out_buf.sv
rtl/core/lsb_stego_payload_extractor_core.sv
rtl/core/lspe_checker.sv
bench/lsb_stego_payload_extractor_core_test.sv
